// File: hw/rtl/decision_tree_store_and_predict_assert.svh
// Assertion macros for the RTL of the decision tree block, included by dtsp_ctrl.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef DECISION_TREE_STORE_AND_PREDICT_ASSERT_SVH
`define DECISION_TREE_STORE_AND_PREDICT_ASSERT_SVH

`ifndef SYNTH
`define DTSP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dtsp: same-cycle check failed");
`define DTSP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dtsp: next-cycle check failed");
`else
`define DTSP_ASSERT_IMP(name, ante, cons)
`define DTSP_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: hw/rtl/dtsp_pkg.sv
`default_nettype none

package dtsp_pkg;

    localparam int TREES    = 64;
    localparam int NODES    = 128;
    localparam int FEATURES = 64;

    localparam int TREE_W   = $clog2(TREES);
    localparam int NODE_W   = $clog2(NODES);
    localparam int FEAT_W   = $clog2(FEATURES);
    localparam int ADDR_W   = TREE_W + NODE_W;
    localparam int CNT_W    = $clog2(NODES + 1);
    localparam int STEP_W   = $clog2(NODES + 1);
    localparam int NUM_W    = 32;
    localparam int TYPE_W   = 2;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam int S_FIELDS_W = TREE_W + NODE_W + TYPE_W + FEAT_W + NUM_W + 2 * NODE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = NODE_W + NUM_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_NODE     = 3'd0,
        KIND_SET_SPLIT    = 3'd1,
        KIND_SET_LEAF     = 3'd2,
        KIND_LOAD_FEATURE = 3'd3,
        KIND_PREDICT      = 3'd4
    } kind_t;

    localparam logic [TYPE_W-1:0]   TYPE_UNUSED = 2'd0;
    localparam logic [TYPE_W-1:0]   TYPE_SPLIT  = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_NODE,
        ST_FEAT,
        ST_DONE
    } state_t;

    // Layout of s_tdata, highest field first.
    typedef struct packed {
        logic [S_TDATA_W-S_FIELDS_W-1:0] pad;
        logic [NODE_W-1:0]               right_next;
        logic [NODE_W-1:0]               left_next;
        logic signed [NUM_W-1:0]         number;
        logic [FEAT_W-1:0]               feature_sel;
        logic [TYPE_W-1:0]               new_type;
        logic [NODE_W-1:0]               slot;
        logic [TREE_W-1:0]               tree;
    } in_data_t;

    // Layout of m_tdata, highest field first.
    typedef struct packed {
        logic [M_TDATA_W-M_FIELDS_W-1:0] pad;
        logic signed [NUM_W-1:0]         prediction;
        logic [NODE_W-1:0]               new_index;
    } out_data_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [TREE_W-1:0]       tree;
        logic [NODE_W-1:0]       slot;
        logic [TYPE_W-1:0]       new_type;
        logic [FEAT_W-1:0]       feature_sel;
        logic signed [NUM_W-1:0] number;
        logic [NODE_W-1:0]       left_next;
        logic [NODE_W-1:0]       right_next;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [NODE_W-1:0]       new_index;
        logic signed [NUM_W-1:0] prediction;
    } res_t;

    // One word of the split memory.
    typedef struct packed {
        logic [FEAT_W-1:0]       feat;
        logic signed [NUM_W-1:0] thr;
        logic [NODE_W-1:0]       left;
        logic [NODE_W-1:0]       right;
    } split_t;

endpackage

`default_nettype wire

// File: hw/rtl/dtsp_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data
// that holds its value while no read is requested.
module dtsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/dtsp_ctrl.sv
`default_nettype none

// Sequencer around the node, count and feature memories. It runs one item at
// a time: memory reads are issued on the accept edge, the data is used in the
// cycle after, and every write lands before the next item can issue a read,
// so no access to an entry ever overlaps with another.
module dtsp_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dtsp_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    output dtsp_pkg::res_t     res,
    output logic               res_valid,
    input  wire logic          res_ready
);

`include "decision_tree_store_and_predict_assert.svh"

    dtsp_pkg::state_t state_reg, state_next;
    dtsp_pkg::cmd_t   cmd_reg, cmd_next;
    dtsp_pkg::res_t   res_reg, res_next;
    logic [dtsp_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic [dtsp_pkg::ADDR_W-1:0] clr_reg, clr_next;

    logic                          accept;
    logic                          is_le;

    logic                          node_re;
    logic [dtsp_pkg::ADDR_W-1:0]   node_raddr;
    logic [dtsp_pkg::ADDR_W-1:0]   node_waddr;
    logic                          type_we;
    logic [dtsp_pkg::TYPE_W-1:0]   type_wdata;
    logic [dtsp_pkg::TYPE_W-1:0]   type_rdata;
    logic                          split_we;
    dtsp_pkg::split_t              split_wdata;
    dtsp_pkg::split_t              split_rdata;
    logic                          leaf_we;
    logic [dtsp_pkg::NUM_W-1:0]    leaf_wdata;
    logic [dtsp_pkg::NUM_W-1:0]    leaf_rdata;

    logic                          cnt_we;
    logic [dtsp_pkg::TREE_W-1:0]   cnt_waddr;
    logic [dtsp_pkg::CNT_W-1:0]    cnt_wdata;
    logic                          cnt_re;
    logic [dtsp_pkg::TREE_W-1:0]   cnt_raddr;
    logic [dtsp_pkg::CNT_W-1:0]    cnt_rdata;

    logic                          feat_we;
    logic [dtsp_pkg::FEAT_W-1:0]   feat_waddr;
    logic [dtsp_pkg::NUM_W-1:0]    feat_wdata;
    logic                          feat_re;
    logic [dtsp_pkg::FEAT_W-1:0]   feat_raddr;
    logic [dtsp_pkg::NUM_W-1:0]    feat_rdata;

    dtsp_ram #(.WIDTH(dtsp_pkg::TYPE_W), .DEPTH(dtsp_pkg::TREES * dtsp_pkg::NODES)) u_type_ram (
        .aclk(aclk), .we(type_we), .waddr(node_waddr), .wdata(type_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(type_rdata)
    );

    dtsp_ram #(
        .WIDTH($bits(dtsp_pkg::split_t)), .DEPTH(dtsp_pkg::TREES * dtsp_pkg::NODES)
    ) u_split_ram (
        .aclk(aclk), .we(split_we), .waddr(node_waddr), .wdata(split_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(split_rdata)
    );

    dtsp_ram #(.WIDTH(dtsp_pkg::NUM_W), .DEPTH(dtsp_pkg::TREES * dtsp_pkg::NODES)) u_leaf_ram (
        .aclk(aclk), .we(leaf_we), .waddr(node_waddr), .wdata(leaf_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(leaf_rdata)
    );

    dtsp_ram #(.WIDTH(dtsp_pkg::CNT_W), .DEPTH(dtsp_pkg::TREES)) u_count_ram (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    dtsp_ram #(.WIDTH(dtsp_pkg::NUM_W), .DEPTH(dtsp_pkg::FEATURES)) u_feature_ram (
        .aclk(aclk), .we(feat_we), .waddr(feat_waddr), .wdata(feat_wdata),
        .re(feat_re), .raddr(feat_raddr), .rdata(feat_rdata)
    );

    assign cmd_ready = (state_reg == dtsp_pkg::ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = (state_reg == dtsp_pkg::ST_DONE);
    assign res       = res_reg;
    assign is_le     = ($signed(feat_rdata) <= split_rdata.thr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dtsp_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        steps_reg <= steps_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dtsp_pkg::ST_CLEAR: begin
                if (clr_reg == dtsp_pkg::ADDR_W'(dtsp_pkg::TREES * dtsp_pkg::NODES - 1)) begin
                    state_next = dtsp_pkg::ST_IDLE;
                end
            end
            dtsp_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (cmd.kind == dtsp_pkg::KIND_PREDICT) ?
                                 dtsp_pkg::ST_NODE : dtsp_pkg::ST_EXEC;
                end
            end
            dtsp_pkg::ST_EXEC: begin
                state_next = dtsp_pkg::ST_DONE;
            end
            dtsp_pkg::ST_NODE: begin
                if (type_rdata == dtsp_pkg::TYPE_SPLIT &&
                    steps_reg < dtsp_pkg::STEP_W'(dtsp_pkg::NODES)) begin
                    state_next = dtsp_pkg::ST_FEAT;
                end else begin
                    state_next = dtsp_pkg::ST_DONE;
                end
            end
            dtsp_pkg::ST_FEAT: begin
                state_next = dtsp_pkg::ST_NODE;
            end
            dtsp_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = dtsp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dtsp_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd_next    = cmd_reg;
        res_next    = res_reg;
        steps_next  = steps_reg;
        clr_next    = clr_reg;

        node_re     = 1'b0;
        node_raddr  = {cmd_reg.tree, dtsp_pkg::NODE_W'(0)};
        node_waddr  = {cmd_reg.tree, cmd_reg.slot};
        type_we     = 1'b0;
        type_wdata  = dtsp_pkg::TYPE_UNUSED;
        split_we    = 1'b0;
        split_wdata = '{feat: cmd_reg.feature_sel, thr: cmd_reg.number,
                        left: cmd_reg.left_next, right: cmd_reg.right_next};
        leaf_we     = 1'b0;
        leaf_wdata  = cmd_reg.number;
        cnt_we      = 1'b0;
        cnt_waddr   = cmd_reg.tree;
        cnt_wdata   = cnt_rdata + dtsp_pkg::CNT_W'(1);
        cnt_re      = 1'b0;
        cnt_raddr   = cmd.tree;
        feat_we     = 1'b0;
        feat_waddr  = cmd_reg.feature_sel;
        feat_wdata  = cmd_reg.number;
        feat_re     = 1'b0;
        feat_raddr  = split_rdata.feat;

        case (state_reg)
            dtsp_pkg::ST_CLEAR: begin
                // Stores with a defined reset value are zeroed one entry a cycle.
                node_waddr = clr_reg;
                type_we    = 1'b1;
                leaf_we    = 1'b1;
                leaf_wdata = '0;
                cnt_we     = 1'b1;
                cnt_waddr  = clr_reg[dtsp_pkg::TREE_W-1:0];
                cnt_wdata  = '0;
                feat_we    = 1'b1;
                feat_waddr = clr_reg[dtsp_pkg::FEAT_W-1:0];
                feat_wdata = '0;
                clr_next   = clr_reg + dtsp_pkg::ADDR_W'(1);
            end
            dtsp_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_next   = cmd;
                    steps_next = '0;
                    cnt_re     = 1'b1;
                    node_re    = 1'b1;
                    node_raddr = {cmd.tree, dtsp_pkg::NODE_W'(0)};
                end
            end
            dtsp_pkg::ST_EXEC: begin
                // Tree, slot and feature fields are as wide as their ranges, so
                // they are always in range here.
                res_next = '0;
                case (cmd_reg.kind)
                    dtsp_pkg::KIND_ADD_NODE: begin
                        if (cnt_rdata >= dtsp_pkg::CNT_W'(dtsp_pkg::NODES)) begin
                            res_next.status = dtsp_pkg::STATUS_FULL;
                        end else begin
                            node_waddr         = {cmd_reg.tree, cnt_rdata[dtsp_pkg::NODE_W-1:0]};
                            type_we            = 1'b1;
                            type_wdata         = cmd_reg.new_type;
                            cnt_we             = 1'b1;
                            res_next.new_index = cnt_rdata[dtsp_pkg::NODE_W-1:0];
                        end
                    end
                    dtsp_pkg::KIND_SET_SPLIT: begin
                        type_we    = 1'b1;
                        type_wdata = dtsp_pkg::TYPE_SPLIT;
                        split_we   = 1'b1;
                    end
                    dtsp_pkg::KIND_SET_LEAF: begin
                        leaf_we = 1'b1;
                    end
                    dtsp_pkg::KIND_LOAD_FEATURE: begin
                        feat_we = 1'b1;
                    end
                    default: begin
                        res_next = '0;
                    end
                endcase
            end
            dtsp_pkg::ST_NODE: begin
                res_next = '0;
                if (type_rdata == dtsp_pkg::TYPE_SPLIT) begin
                    if (steps_reg >= dtsp_pkg::STEP_W'(dtsp_pkg::NODES)) begin
                        res_next.status = dtsp_pkg::STATUS_LONG;
                    end else begin
                        feat_re    = 1'b1;
                        steps_next = steps_reg + dtsp_pkg::STEP_W'(1);
                    end
                end else begin
                    res_next.prediction = leaf_rdata;
                end
            end
            dtsp_pkg::ST_FEAT: begin
                node_re    = 1'b1;
                node_raddr = {cmd_reg.tree, is_le ? split_rdata.left : split_rdata.right};
            end
            dtsp_pkg::ST_DONE: begin
                res_next = res_reg;
            end
            default: begin
                res_next = res_reg;
            end
        endcase
    end

    `DTSP_ASSERT_IMP(a_no_write_in_walk, (state_reg == dtsp_pkg::ST_NODE) || (state_reg == dtsp_pkg::ST_FEAT), !(type_we || split_we || leaf_we || cnt_we || feat_we))
    `DTSP_ASSERT_IMP(a_steps_bounded, state_reg == dtsp_pkg::ST_FEAT, (steps_reg != '0) && (steps_reg <= dtsp_pkg::STEP_W'(dtsp_pkg::NODES)))
    `DTSP_ASSERT_NEXT(a_accept_leaves_idle, cmd_valid && cmd_ready, state_reg != dtsp_pkg::ST_IDLE)
    `DTSP_ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(res))

endmodule

`default_nettype wire

// File: hw/rtl/decision_tree_store_and_predict.sv
`default_nettype none

// Channel  Direction  Handshake           Payload
// s_       in         s_tvalid/s_tready   s_tuser = kind, s_tdata = node and feature fields
// m_       out        m_tvalid/m_tready   m_tuser = status, m_tdata = new_index, prediction
//
// After reset a clearing pass zeroes node types, leaf values, fill counts and
// the feature vector, one entry a cycle with s_tready low. Add node, set split,
// set leaf and load feature pass the execute and done states; predict has a
// node and a feature state per split node, as every level is a node memory
// read followed by a dependent feature memory read. A finished item waits in
// the output register, so back-pressure stalls input only at a second result.
module decision_tree_store_and_predict (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // From bit 0: tree, slot, new_type, feature_sel, number, left_next,
    // right_next, zero fill.
    input  wire logic [dtsp_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic [dtsp_pkg::KIND_W-1:0]    s_tuser,

    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // From bit 0: new_index, prediction, zero fill.
    output logic      [dtsp_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic      [dtsp_pkg::STATUS_W-1:0]  m_tuser
);

    dtsp_pkg::in_data_t  s_data;
    dtsp_pkg::out_data_t m_data;
    dtsp_pkg::cmd_t      cmd;
    dtsp_pkg::res_t      res;
    logic                res_valid;
    logic                res_ready;

    // Output register: one finished item waits here for the sink.
    logic                m_valid_reg, m_valid_next;
    dtsp_pkg::res_t      m_res_reg, m_res_next;

    assign s_data = dtsp_pkg::in_data_t'(s_tdata);

    assign cmd.kind        = s_tuser;
    assign cmd.tree        = s_data.tree;
    assign cmd.slot        = s_data.slot;
    assign cmd.new_type    = s_data.new_type;
    assign cmd.feature_sel = s_data.feature_sel;
    assign cmd.number      = s_data.number;
    assign cmd.left_next   = s_data.left_next;
    assign cmd.right_next  = s_data.right_next;

    dtsp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // The register can take a new item when it is empty or drains this cycle.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_data.pad        = '0;
    assign m_data.prediction = m_res_reg.prediction;
    assign m_data.new_index  = m_res_reg.new_index;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data;
    assign m_tuser  = m_res_reg.status;

endmodule

`default_nettype wire
